// ===== design/lelp_pkg.sv =====
package lelp_pkg;

  localparam int MAX_LEDS_DEF        = 1024;
  localparam int STATE_FRAC_BITS_DEF = 24;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [23:0] SIGMA_RST = 24'd655360;
  localparam logic [23:0] RHO_RST   = 24'd1835008;
  localparam logic [23:0] BETA_RST  = 24'd174763;
  localparam logic [10:0] LEDS_RST  = 11'd1024;
  localparam logic [31:0] START_RST = 32'd9686330;

  typedef enum logic [2:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_LEDS    = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6,
    REG_NONE    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_DX    = 4'd0,
    OP_XRHO  = 4'd1,
    OP_XZ    = 4'd2,
    OP_XY    = 4'd3,
    OP_BZ    = 4'd4,
    OP_HI_X  = 4'd5,
    OP_LO_X  = 4'd6,
    OP_HI_Y  = 4'd7,
    OP_LO_Y  = 4'd8,
    OP_HI_Z  = 4'd9,
    OP_LO_Z  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_MARK,
    S_IMUL,
    S_ISET,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== design/lelp_if.sv =====
interface lelp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_size;
  logic        restart;
  modport source (output valid, step_size, restart, input ready);
  modport sink   (input valid, step_size, restart, output ready);
endinterface

interface lelp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [9:0]         red_index;
  logic [9:0]         green_index;
  logic [9:0]         blue_index;
  modport source (output valid, pos_x, pos_y, pos_z, red_index, green_index, blue_index,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, red_index, green_index, blue_index,
                  output ready);
endinterface

// ===== design/lorenz_euler_led_position.sv =====
// Lorenz attractor stepper with LED position mapping.
// in_ch carries one time step (step_size, restart); out_ch returns the new
// coordinates pos_x/y/z and their LED indexes red/green/blue_index.
// Configuration registers sit on the APB port at byte address 4*i:
// sigma, rho, beta, led_count, start_x, start_y, start_z; reads return them.
// One shared 33x33 multiplier with a registered product does all the work:
// eleven products for the Euler step, then for each of the three axes one
// product and a restoring divider for a clog2(MAX_LEDS)-bit quotient. One
// item is in work at a time and in_ch is not ready meanwhile.
// The result sits in an output register; the next item is taken while it
// waits, but its result is held back until out_ch has taken the previous.
// Reset (rst, synchronous) restores the register defaults, loads the start
// point and empties the min/max trackers. restart = 1 does the same for the
// coordinates and trackers before stepping.
module lorenz_euler_led_position #(
  parameter int MAX_LEDS        = lelp_pkg::MAX_LEDS_DEF,
  parameter int STATE_FRAC_BITS = lelp_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lelp_in_if.sink     in_ch,
  lelp_out_if.source  out_ch
);

  localparam int QB = $clog2(MAX_LEDS);
  localparam int NW = 33 + QB;
  localparam int DW = 49;
  localparam int AW = 52;
  localparam int CW = 32;

  logic [23:0] sigma_gain, rho_gain, beta_gain;
  logic [10:0] led_count;
  logic signed [31:0] start_x, start_y, start_z;

  lelp_pkg::reg_idx_t widx;
  assign widx   = lelp_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_gain <= lelp_pkg::SIGMA_RST;
      rho_gain   <= lelp_pkg::RHO_RST;
      beta_gain  <= lelp_pkg::BETA_RST;
      led_count  <= lelp_pkg::LEDS_RST;
      start_x    <= lelp_pkg::START_RST;
      start_y    <= lelp_pkg::START_RST;
      start_z    <= lelp_pkg::START_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        lelp_pkg::REG_SIGMA:   sigma_gain <= pwdata[23:0];
        lelp_pkg::REG_RHO:     rho_gain   <= pwdata[23:0];
        lelp_pkg::REG_BETA:    beta_gain  <= pwdata[23:0];
        lelp_pkg::REG_LEDS:    led_count  <= pwdata[10:0];
        lelp_pkg::REG_START_X: start_x    <= pwdata;
        lelp_pkg::REG_START_Y: start_y    <= pwdata;
        lelp_pkg::REG_START_Z: start_z    <= pwdata;
        lelp_pkg::REG_NONE:    ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      lelp_pkg::REG_SIGMA:   prdata = {8'd0, sigma_gain};
      lelp_pkg::REG_RHO:     prdata = {8'd0, rho_gain};
      lelp_pkg::REG_BETA:    prdata = {8'd0, beta_gain};
      lelp_pkg::REG_LEDS:    prdata = {21'd0, led_count};
      lelp_pkg::REG_START_X: prdata = start_x;
      lelp_pkg::REG_START_Y: prdata = start_y;
      lelp_pkg::REG_START_Z: prdata = start_z;
      lelp_pkg::REG_NONE:    prdata = 32'd0;
    endcase
  end

  // effective LED count minus one
  logic [31:0] lc_wide;
  logic [QB-1:0] nm1;
  always_comb begin
    lc_wide = {21'd0, led_count};
    if (lc_wide == 32'd0) begin
      nm1 = '0;
    end else if (lc_wide > 32'(MAX_LEDS)) begin
      nm1 = QB'(MAX_LEDS - 1);
    end else begin
      nm1 = QB'(lc_wide - 32'd1);
    end
  end

  lelp_pkg::state_t state, state_next;
  lelp_pkg::op_t op;
  logic [1:0] axis;
  logic [$clog2(QB+1)-1:0] bitn;

  logic signed [CW-1:0] coord [3];
  logic signed [CW-1:0] low_marks [3];
  logic signed [CW-1:0] high_marks [3];
  logic signed [DW-1:0] deriv [3];
  logic signed [DW-1:0] tmp;
  logic signed [AW-1:0] acc;
  logic [15:0] dt;
  logic [NW-1:0] num, sd;
  logic [QB-1:0] quo;
  logic [9:0] idx [3];

  logic signed [CW-1:0] res_pos [3];
  logic [9:0] res_idx [3];
  logic res_valid;

  logic signed [lelp_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [lelp_pkg::PROD_W-1:0] prod;

  lelp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  logic signed [lelp_pkg::PROD_W-1:0] p16, pf;
  assign p16 = prod >>> 16;
  assign pf  = prod >>> STATE_FRAC_BITS;

  logic [1:0] op_axis;
  logic signed [DW-1:0] dhi_full;
  logic signed [32:0] off, span;
  logic [31:0] qw;

  always_comb begin
    unique case (op)
      lelp_pkg::OP_HI_Y, lelp_pkg::OP_LO_Y: op_axis = 2'd1;
      lelp_pkg::OP_HI_Z, lelp_pkg::OP_LO_Z: op_axis = 2'd2;
      default:                              op_axis = 2'd0;
    endcase
    dhi_full = deriv[op_axis] >>> 16;
    off  = $signed({coord[axis][31], coord[axis]}) -
           $signed({low_marks[axis][31], low_marks[axis]});
    span = $signed({high_marks[axis][31], high_marks[axis]}) -
           $signed({low_marks[axis][31], low_marks[axis]});
    qw = 32'(quo);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == lelp_pkg::S_IMUL) begin
      mul_a = off;
      mul_b = $signed(33'(nm1));
    end else begin
      unique case (op)
        lelp_pkg::OP_DX: begin
          mul_a = $signed({9'd0, sigma_gain});
          mul_b = $signed({coord[1][31], coord[1]}) - $signed({coord[0][31], coord[0]});
        end
        lelp_pkg::OP_XRHO: begin
          mul_a = 33'(coord[0]);
          mul_b = $signed({9'd0, rho_gain});
        end
        lelp_pkg::OP_XZ: begin
          mul_a = 33'(coord[0]);
          mul_b = 33'(coord[2]);
        end
        lelp_pkg::OP_XY: begin
          mul_a = 33'(coord[0]);
          mul_b = 33'(coord[1]);
        end
        lelp_pkg::OP_BZ: begin
          mul_a = $signed({9'd0, beta_gain});
          mul_b = 33'(coord[2]);
        end
        lelp_pkg::OP_HI_X, lelp_pkg::OP_HI_Y, lelp_pkg::OP_HI_Z: begin
          mul_a = dhi_full[32:0];
          mul_b = $signed({17'd0, dt});
        end
        lelp_pkg::OP_LO_X, lelp_pkg::OP_LO_Y, lelp_pkg::OP_LO_Z: begin
          mul_a = $signed({17'd0, deriv[op_axis][15:0]});
          mul_b = $signed({17'd0, dt});
        end
        default: ;
      endcase
    end
  end

  logic out_free;
  assign out_free     = !res_valid || out_ch.ready;
  assign in_ch.ready  = (state == lelp_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      lelp_pkg::S_IDLE: if (in_ch.valid) state_next = lelp_pkg::S_MUL;
      lelp_pkg::S_MUL:  state_next = lelp_pkg::S_EVAL;
      lelp_pkg::S_EVAL: state_next = (op == lelp_pkg::OP_LO_Z) ? lelp_pkg::S_MARK
                                                               : lelp_pkg::S_MUL;
      lelp_pkg::S_MARK: state_next = lelp_pkg::S_IMUL;
      lelp_pkg::S_IMUL: state_next = lelp_pkg::S_ISET;
      lelp_pkg::S_ISET: state_next = lelp_pkg::S_DIV;
      lelp_pkg::S_DIV: begin
        if (bitn == '0) begin
          state_next = (axis == 2'd2) ? lelp_pkg::S_DONE : lelp_pkg::S_IMUL;
        end
      end
      lelp_pkg::S_DONE: if (out_free) state_next = lelp_pkg::S_IDLE;
      default: state_next = lelp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lelp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic signed [AW-1:0] total;
  logic [NW-1:0] num_sub;
  assign total   = acc + AW'(p16);
  assign num_sub = num - sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord[0] <= lelp_pkg::START_RST;
      coord[1] <= lelp_pkg::START_RST;
      coord[2] <= lelp_pkg::START_RST;
      for (int i = 0; i < 3; i++) begin
        low_marks[i]  <= 32'sh7FFFFFFF;
        high_marks[i] <= 32'sh80000000;
      end
      op        <= lelp_pkg::OP_DX;
      axis      <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      if (state == lelp_pkg::S_DONE && out_free) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
      unique case (state)
        lelp_pkg::S_IDLE: begin
          if (in_ch.valid) begin
            dt <= in_ch.step_size;
            op <= lelp_pkg::OP_DX;
            if (in_ch.restart) begin
              coord[0] <= start_x;
              coord[1] <= start_y;
              coord[2] <= start_z;
              for (int i = 0; i < 3; i++) begin
                low_marks[i]  <= 32'sh7FFFFFFF;
                high_marks[i] <= 32'sh80000000;
              end
            end
          end
        end
        lelp_pkg::S_EVAL: begin
          op <= lelp_pkg::op_t'(op + 4'd1);
          unique case (op)
            lelp_pkg::OP_DX:   deriv[0] <= p16[DW-1:0];
            lelp_pkg::OP_XRHO: tmp <= p16[DW-1:0];
            lelp_pkg::OP_XZ:   deriv[1] <= tmp - pf[DW-1:0] - DW'(coord[1]);
            lelp_pkg::OP_XY:   tmp <= pf[DW-1:0];
            lelp_pkg::OP_BZ:   deriv[2] <= tmp - p16[DW-1:0];
            lelp_pkg::OP_HI_X, lelp_pkg::OP_HI_Y, lelp_pkg::OP_HI_Z:
              acc <= AW'(coord[op_axis]) + prod[AW-1:0];
            lelp_pkg::OP_LO_X, lelp_pkg::OP_LO_Y, lelp_pkg::OP_LO_Z: begin
              if (total > AW'(32'sh7FFFFFFF)) begin
                coord[op_axis] <= 32'sh7FFFFFFF;
              end else if (total < AW'(32'sh80000000)) begin
                coord[op_axis] <= 32'sh80000000;
              end else begin
                coord[op_axis] <= total[31:0];
              end
            end
            default: ;
          endcase
        end
        lelp_pkg::S_MARK: begin
          for (int i = 0; i < 3; i++) begin
            if (coord[i] < low_marks[i])  low_marks[i]  <= coord[i];
            if (coord[i] > high_marks[i]) high_marks[i] <= coord[i];
          end
          axis <= 2'd0;
        end
        lelp_pkg::S_ISET: begin
          num  <= prod[NW-1:0];
          sd   <= NW'(span) << (QB - 1);
          bitn <= ($clog2(QB+1))'(QB - 1);
          quo  <= '0;
        end
        lelp_pkg::S_DIV: begin
          if (num >= sd) begin
            num <= num_sub;
            quo <= quo | (QB'(1) << bitn);
          end
          sd <= sd >> 1;
          if (bitn == '0) begin
            idx[axis] <= (span == 33'sd0) ? 10'd0
                       : ((num >= sd) ? (qw[9:0] | 10'(QB'(1) << bitn)) : qw[9:0]);
            axis <= axis + 2'd1;
          end else begin
            bitn <= bitn - 1'b1;
          end
        end
        lelp_pkg::S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              res_pos[i] <= coord[i];
              res_idx[i] <= idx[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.pos_x       = res_pos[0];
  assign out_ch.pos_y       = res_pos[1];
  assign out_ch.pos_z       = res_pos[2];
  assign out_ch.red_index   = res_idx[0];
  assign out_ch.green_index = res_idx[1];
  assign out_ch.blue_index  = res_idx[2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted transaction did not start work");

  a_marks_cover_x: assert property (@(posedge clk) disable iff (rst)
    state == lelp_pkg::S_DONE |-> low_marks[0] <= coord[0] && coord[0] <= high_marks[0])
    else $error("range tracker does not cover x");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    state == lelp_pkg::S_DONE && out_free |=> out_ch.valid && out_ch.pos_z == coord[2])
    else $error("result not presented");

endmodule

// ===== design/lelp_mul.sv =====
module lelp_mul (
  input  logic                               clk,
  input  logic signed [lelp_pkg::MUL_W-1:0]  a,
  input  logic signed [lelp_pkg::MUL_W-1:0]  b,
  output logic signed [lelp_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
